>>> rtl/gcc_pkg.sv
`timescale 1ns / 1ps
package gcc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_COLORS   = 64;

    localparam int REQ_W    = 3;
    localparam int VTX_W    = 6;
    localparam int COLOR_W  = 6;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 7;
    localparam int ADDR_W   = $clog2(MAX_VERTICES);
    localparam int NV_W     = $clog2(MAX_VERTICES + 1);
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [REQ_W-1:0] REQ_SET_EDGE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COLOR      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_VTX_CONF   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TOTAL_CONF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

    localparam logic [VTX_W:0]   MAXV_EXT  = (VTX_W + 1)'(MAX_VERTICES);
    localparam logic [COLOR_W:0] MAXC_EXT  = (COLOR_W + 1)'(MAX_COLORS);
    localparam logic [CFG_W-1:0] MAXV_CFG  = CFG_W'(MAX_VERTICES);
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VTX_W-1:0]   vertex;
        logic [VTX_W-1:0]   other_vertex;
        logic               edge_bit;
        logic [COLOR_W-1:0] color;
    } t_request;

    typedef struct packed {
        logic [COUNT_W-1:0] conflict_count;
        logic               feasible;
        logic               has_neighbour;
        logic [VTX_W-1:0]   neighbour;
        logic [COLOR_W-1:0] neighbour_color;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]       row_raddr;
        logic                    row_we;
        logic [ADDR_W-1:0]       row_waddr;
        logic [MAX_VERTICES-1:0] row_wdata;
        logic [ADDR_W-1:0]       col_raddr;
        logic                    col_we;
        logic [ADDR_W-1:0]       col_waddr;
        logic [COLOR_W-1:0]      col_wdata;
    } t_mem_req;

    function automatic logic vtx_ok(input logic [VTX_W-1:0] v);
        return {1'b0, v} < MAXV_EXT;
    endfunction

    function automatic logic color_ok(input logic [COLOR_W-1:0] c);
        return {1'b0, c} < MAXC_EXT;
    endfunction

endpackage

>>> rtl/gcc_ram.sv
`timescale 1ns / 1ps
module gcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

>>> rtl/gcc_store.sv
`timescale 1ns / 1ps
module gcc_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gcc_pkg::t_mem_req                i_mem,
    output logic [gcc_pkg::MAX_VERTICES-1:0] o_row_rd,
    output logic [gcc_pkg::COLOR_W-1:0]      o_col_rd
);
    import gcc_pkg::*;

    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_col_vld;
    logic                    r_row_rv;
    logic                    r_col_rv;
    logic [MAX_VERTICES-1:0] w_row_q;
    logic [COLOR_W-1:0]      w_col_q;

    gcc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_mem.row_we),
        .i_waddr (i_mem.row_waddr),
        .i_wdata (i_mem.row_wdata),
        .i_raddr (i_mem.row_raddr),
        .o_rdata (w_row_q)
    );

    gcc_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_VERTICES)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (i_mem.col_we),
        .i_waddr (i_mem.col_waddr),
        .i_wdata (i_mem.col_wdata),
        .i_raddr (i_mem.col_raddr),
        .o_rdata (w_col_q)
    );

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_col_vld <= '0;
            r_row_rv  <= 1'b0;
            r_col_rv  <= 1'b0;
        end else begin
            if (i_mem.row_we) begin
                r_row_vld[i_mem.row_waddr] <= 1'b1;
            end
            if (i_mem.col_we) begin
                r_col_vld[i_mem.col_waddr] <= 1'b1;
            end
            r_row_rv <= r_row_vld[i_mem.row_raddr];
            r_col_rv <= r_col_vld[i_mem.col_raddr];
        end
    end

    assign o_row_rd = r_row_rv ? w_row_q : '0;
    assign o_col_rd = r_col_rv ? w_col_q : '0;
endmodule

>>> rtl/gcc_seq.sv
`timescale 1ns / 1ps
module gcc_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gcc_pkg::t_request                i_req,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [gcc_pkg::NV_W-1:0]         i_active,
    input  logic [gcc_pkg::MAX_VERTICES-1:0] i_row_rd,
    input  logic [gcc_pkg::COLOR_W-1:0]      i_col_rd,
    output gcc_pkg::t_mem_req                o_mem,
    output gcc_pkg::t_result                 o_res,
    output logic                             o_res_valid,
    input  logic                             i_res_ready
);
    import gcc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RMW  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [REQ_W-1:0]        r_kind, n_kind;
    logic [ADDR_W-1:0]       r_v, n_v;
    logic [ADDR_W-1:0]       r_w, n_w;
    logic                    r_bit, n_bit;
    logic                    r_vbad, n_vbad;
    logic [ADDR_W-1:0]       r_i, n_i;
    logic [ADDR_W-1:0]       r_j, n_j;
    logic [MAX_VERTICES-1:0] r_row, n_row;
    logic [COLOR_W-1:0]      r_refc, n_refc;
    logic [COUNT_W-1:0]      r_cnt, n_cnt;
    logic                    r_pend, n_pend;
    logic [ADDR_W-1:0]       r_pend_nb, n_pend_nb;
    logic [COLOR_W-1:0]      r_pend_c, n_pend_c;

    logic [ADDR_W-1:0]       w_v_a;
    logic [ADDR_W-1:0]       w_i_inc;
    logic [ADDR_W-1:0]       w_j_inc;
    logic [NV_W-1:0]         w_i_nx;
    logic [NV_W-1:0]         w_j_nx;
    logic                    w_last_j;
    logic                    w_edge;
    logic                    w_same;
    logic                    w_self;
    logic                    w_nb;
    logic                    w_stall;
    logic [MAX_VERTICES-1:0] w_row_new;

    assign w_v_a    = i_req.vertex[ADDR_W-1:0];
    assign w_i_inc  = r_i + 1'b1;
    assign w_j_inc  = r_j + 1'b1;
    assign w_i_nx   = NV_W'(r_i) + NV_W'(1);
    assign w_j_nx   = NV_W'(r_j) + NV_W'(1);
    assign w_last_j = (w_j_nx == i_active);

    // shared compare unit: one stored colour against the reference each cycle unless the list scan stalls
    assign w_edge  = r_row[r_j];
    assign w_same  = (i_col_rd == r_refc);
    assign w_self  = (r_j == r_v);
    assign w_nb    = w_edge && !w_self;
    assign w_stall = (r_kind == REQ_LIST) && w_nb && r_pend && !i_res_ready;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        w_row_new        = i_row_rd;
        w_row_new[r_w]   = r_bit;
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_v       = r_v;
        n_w       = r_w;
        n_bit     = r_bit;
        n_vbad    = r_vbad;
        n_i       = r_i;
        n_j       = r_j;
        n_row     = r_row;
        n_refc    = r_refc;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_pend_nb = r_pend_nb;
        n_pend_c  = r_pend_c;

        o_mem.row_raddr = r_v;
        o_mem.row_we    = 1'b0;
        o_mem.row_waddr = r_v;
        o_mem.row_wdata = w_row_new;
        o_mem.col_raddr = r_j;
        o_mem.col_we    = 1'b0;
        o_mem.col_waddr = w_v_a;
        o_mem.col_wdata = i_req.color;

        o_res_valid           = 1'b0;
        o_res.conflict_count  = r_cnt;
        o_res.feasible        = 1'b0;
        o_res.has_neighbour   = 1'b0;
        o_res.neighbour       = '0;
        o_res.neighbour_color = '0;
        o_res.last            = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.req_type == REQ_TOTAL_CONF) begin
                    o_mem.row_raddr = '0;
                    o_mem.col_raddr = '0;
                end else begin
                    o_mem.row_raddr = w_v_a;
                    o_mem.col_raddr = w_v_a;
                end
                if (i_req_valid) begin
                    n_kind = i_req.req_type;
                    n_v    = w_v_a;
                    n_w    = i_req.other_vertex[ADDR_W-1:0];
                    n_bit  = i_req.edge_bit;
                    n_vbad = !vtx_ok(i_req.vertex);
                    n_i    = '0;
                    n_cnt  = '0;
                    n_pend = 1'b0;
                    case (i_req.req_type)
                        REQ_SET_EDGE: begin
                            if (vtx_ok(i_req.vertex) && vtx_ok(i_req.other_vertex)) begin
                                n_state = S_RMW;
                            end
                        end
                        REQ_COLOR: begin
                            o_mem.col_we = vtx_ok(i_req.vertex) && color_ok(i_req.color);
                        end
                        REQ_VTX_CONF, REQ_TOTAL_CONF, REQ_LIST: begin
                            n_state = S_LOAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW: begin
                o_mem.row_we = 1'b1;
                n_state      = S_IDLE;
            end
            S_LOAD: begin
                n_row  = i_row_rd;
                n_refc = i_col_rd;
                if (r_kind == REQ_TOTAL_CONF) begin
                    o_mem.col_raddr = w_i_inc;
                    n_j             = w_i_inc;
                    n_state         = (w_i_nx >= i_active) ? S_DONE : S_SCAN;
                end else begin
                    o_mem.col_raddr = '0;
                    n_j             = '0;
                    n_state         = (r_vbad || i_active == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_mem.row_raddr = w_i_inc;
                if (w_stall) begin
                    o_mem.col_raddr = r_j;
                end else if (w_last_j) begin
                    o_mem.col_raddr = w_i_inc;
                end else begin
                    o_mem.col_raddr = w_j_inc;
                end

                case (r_kind)
                    REQ_TOTAL_CONF: begin
                        if (w_edge && w_same) begin
                            n_cnt = r_cnt + COUNT_W'(1);
                        end
                    end
                    REQ_VTX_CONF: begin
                        if (w_nb && w_same) begin
                            n_cnt = r_cnt + COUNT_W'(1);
                        end
                    end
                    default: begin
                        // list: a held neighbour goes out once a later one is found
                        if (w_nb && r_pend) begin
                            o_res_valid           = 1'b1;
                            o_res.has_neighbour   = 1'b1;
                            o_res.neighbour       = VTX_W'(r_pend_nb);
                            o_res.neighbour_color = r_pend_c;
                        end
                        if (w_nb && !w_stall) begin
                            n_pend    = 1'b1;
                            n_pend_nb = r_j;
                            n_pend_c  = i_col_rd;
                            if (r_pend) begin
                                n_cnt = r_cnt + COUNT_W'(1);
                            end
                        end
                    end
                endcase

                if (!w_stall) begin
                    if (w_last_j) begin
                        if (r_kind == REQ_TOTAL_CONF) begin
                            n_i     = w_i_inc;
                            n_state = S_LOAD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_j = w_j_inc;
                    end
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                if (r_kind == REQ_LIST) begin
                    if (r_pend) begin
                        o_res.has_neighbour   = 1'b1;
                        o_res.neighbour       = VTX_W'(r_pend_nb);
                        o_res.neighbour_color = r_pend_c;
                    end
                end else begin
                    o_res.feasible = (r_cnt == '0);
                end
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_v       <= n_v;
        r_w       <= n_w;
        r_bit     <= n_bit;
        r_vbad    <= n_vbad;
        r_i       <= n_i;
        r_j       <= n_j;
        r_row     <= n_row;
        r_refc    <= n_refc;
        r_cnt     <= n_cnt;
        r_pend    <= n_pend;
        r_pend_nb <= n_pend_nb;
        r_pend_c  <= n_pend_c;
    end
endmodule

>>> rtl/graph_coloring_conflict_counter.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: request operands, tuser: request code
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: count/neighbour, tuser, tlast
// cfg       in   i_cfg_we                      i_cfg_wdata: active vertex count
//
// Color write is done while idle. Edge write: row read-modify-write through the RMW state.
// Vertex conflicts, neighbour list: load vertex row and color, then scan n active vertices,
// one color compared per cycle unless m_axis stalls; total conflicts reloads per vertex.
// Storage is one row RAM and one color RAM, single read port each.
// Synchronous active-low reset clears the graph via per-entry valid flags, no sweep.
// A stalled m_axis holds the list scan; one word of output buffering.
module graph_coloring_conflict_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // vertex[5:0], other_vertex[11:6], edge_bit[12], color[18:13], zero fill
    input  logic [gcc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[2:0]
    input  logic [gcc_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // conflict_count[10:0], feasible[11], neighbour[17:12], neighbour_color[23:18]
    output logic [gcc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // has_neighbour
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [gcc_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import gcc_pkg::*;

    logic [CFG_W-1:0]        r_num_vertices;
    logic [NV_W-1:0]         w_active;
    t_request                w_req;
    t_mem_req                w_mem;
    t_result                 w_res;
    logic                    w_res_valid;
    logic                    w_res_ready;
    logic [MAX_VERTICES-1:0] w_row_rd;
    logic [COLOR_W-1:0]      w_col_rd;
    t_result                 r_out;
    logic                    r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_num_vertices <= i_cfg_wdata;
        end
    end

    assign w_active = (r_num_vertices > MAXV_CFG) ? NV_W'(MAX_VERTICES)
                                                  : r_num_vertices[NV_W-1:0];

    assign w_req.req_type     = s_axis_tuser;
    assign w_req.vertex       = s_axis_tdata[5:0];
    assign w_req.other_vertex = s_axis_tdata[11:6];
    assign w_req.edge_bit     = s_axis_tdata[12];
    assign w_req.color        = s_axis_tdata[18:13];

    gcc_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mem    (w_mem),
        .o_row_rd (w_row_rd),
        .o_col_rd (w_col_rd)
    );

    gcc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_active    (w_active),
        .i_row_rd    (w_row_rd),
        .i_col_rd    (w_col_rd),
        .o_mem       (w_mem),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready)
    );

    // output register: takes a new word while the old one is being taken
    assign w_res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out.neighbour_color, r_out.neighbour,
                            r_out.feasible, r_out.conflict_count};
    assign m_axis_tuser  = r_out.has_neighbour;
    assign m_axis_tlast  = r_out.last;
endmodule
